// File: hdl/gcdr_pkg.sv
package gcdr_pkg;

  // frame characters
  localparam logic [7:0] CH_END = 8'd58;
  localparam logic [7:0] CH_G   = 8'd71;
  localparam logic [7:0] CH_E   = 8'd69;
  localparam logic [7:0] CH_T   = 8'd84;

  // ascii '0' as carried on the 6-bit digit port
  localparam logic [5:0] CH_ZERO = 6'd48;

  // saturated reply digit
  localparam logic [3:0] DIGIT_NINE = 4'd9;

  // frame position at which the prefix has been fully seen
  localparam logic [1:0] POS_FULL = 2'd3;

  // controller to datapath
  typedef struct packed {
    logic accept;       // input transaction taken
    logic load;         // load count, start conversion
    logic convert;      // one shift-and-add-3 step
    logic shift_digit;  // drop the top bcd digit
    logic load_sat;     // reply saturates to all nines
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic reply;      // current byte closes a matching frame
    logic conv_done;  // all count bits shifted in
    logic ovf;        // count needs more digits than allowed
    logic top_zero;   // top bcd digit is zero
    logic rem_one;    // one digit left to send
  } status_t;

  // expected prefix character for a frame position
  function automatic logic [7:0] prefix_char(input logic [1:0] pos);
    logic [7:0] c;
    case (pos)
      2'd0:    c = CH_G;
      2'd1:    c = CH_E;
      default: c = CH_T;
    endcase
    return c;
  endfunction

endpackage

// File: hdl/gcdr_ctrl.sv
module gcdr_ctrl
  import gcdr_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  input  logic    out_stall,
  input  status_t status,
  output cmd_t    cmd,
  output logic    in_stall,
  output logic    out_valid
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CONV = 2'd1;
  localparam logic [1:0] S_SKIP = 2'd2;
  localparam logic [1:0] S_EMIT = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  // handshake follows state
  assign in_stall  = (state != S_IDLE);
  assign out_valid = (state == S_EMIT);

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (status.reply) begin
            cmd.load   = 1'b1;
            state_next = S_CONV;
          end
        end
      end
      S_CONV: begin
        if (!status.conv_done) begin
          cmd.convert = 1'b1;
        end else if (status.ovf) begin
          cmd.load_sat = 1'b1;
          state_next   = S_EMIT;
        end else begin
          state_next = S_SKIP;
        end
      end
      S_SKIP: begin
        if (status.top_zero && !status.rem_one) begin
          cmd.shift_digit = 1'b1;
        end else begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!out_stall) begin
          if (status.rem_one) begin
            state_next = S_IDLE;
          end else begin
            cmd.shift_digit = 1'b1;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// File: hdl/gcdr_dpath.sv
module gcdr_dpath
  import gcdr_pkg::*;
#(
  parameter int COUNT_BITS = 32,
  parameter int MAX_DIGITS = 10
) (
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        cmd,
  input  logic [7:0]  rx_byte,
  input  logic [31:0] step_count,
  output status_t     status,
  output logic [5:0]  digit_char,
  output logic        last_digit
);

  // decimal digits needed for the largest count
  localparam int BCD_DIGITS = (COUNT_BITS * 30103) / 100000 + 1;
  localparam int BCD_BITS   = BCD_DIGITS * 4;
  localparam int REM_MAX    = (BCD_DIGITS > MAX_DIGITS) ? BCD_DIGITS : MAX_DIGITS;
  localparam int REM_W      = $clog2(REM_MAX + 1);
  localparam int BIT_W      = $clog2(COUNT_BITS + 1);

  logic [1:0]            frame_position;
  logic                  prefix_match;
  logic [COUNT_BITS-1:0] bin;
  logic [BCD_BITS-1:0]   bcd;
  logic [BCD_BITS-1:0]   bcd_adj;
  logic [BIT_W-1:0]      bit_cnt;
  logic [REM_W-1:0]      remaining;
  logic                  sat;
  logic                  ovf;
  logic [3:0]            top_digit;

  // frame tracking on each input transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_position <= 2'd0;
      prefix_match   <= 1'b1;
    end else if (cmd.accept) begin
      if (rx_byte == CH_END) begin
        frame_position <= 2'd0;
        prefix_match   <= 1'b1;
      end else if (frame_position != POS_FULL) begin
        if (rx_byte != prefix_char(frame_position)) begin
          prefix_match <= 1'b0;
        end
        frame_position <= frame_position + 2'd1;
      end
    end
  end

  // add 3 to every digit of 5 or more before the shift
  always_comb begin
    bcd_adj = bcd;
    for (int i = 0; i < BCD_DIGITS; i++) begin
      if (bcd[i*4 +: 4] >= 4'd5) begin
        bcd_adj[i*4 +: 4] = bcd[i*4 +: 4] + 4'd3;
      end
    end
  end

  // digits above the allowed count
  always_comb begin
    ovf = 1'b0;
    for (int i = 0; i < BCD_DIGITS; i++) begin
      if (i >= MAX_DIGITS && bcd[i*4 +: 4] != 4'd0) begin
        ovf = 1'b1;
      end
    end
  end

  // conversion and digit registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      bin       <= COUNT_BITS'(step_count);
      bcd       <= '0;
      bit_cnt   <= BIT_W'(COUNT_BITS);
      remaining <= REM_W'(BCD_DIGITS);
      sat       <= 1'b0;
    end else if (cmd.convert) begin
      {bcd, bin} <= {bcd_adj[BCD_BITS-2:0], bin, 1'b0};
      bit_cnt    <= bit_cnt - BIT_W'(1);
    end else if (cmd.load_sat) begin
      remaining <= REM_W'(MAX_DIGITS);
      sat       <= 1'b1;
    end else if (cmd.shift_digit) begin
      bcd       <= {bcd[BCD_BITS-5:0], 4'd0};
      remaining <= remaining - REM_W'(1);
    end
  end

  assign top_digit = sat ? DIGIT_NINE : bcd[BCD_BITS-1 -: 4];

  // status back to the controller
  assign status.reply     = (rx_byte == CH_END) && (frame_position == POS_FULL) && prefix_match;
  assign status.conv_done = (bit_cnt == '0);
  assign status.ovf       = ovf;
  assign status.top_zero  = (bcd[BCD_BITS-1 -: 4] == 4'd0);
  assign status.rem_one   = (remaining == REM_W'(1));

  // result payload
  assign digit_char = CH_ZERO + {2'b00, top_digit};
  assign last_digit = (remaining == REM_W'(1));

endmodule

// File: hdl/get_command_decimal_reply.sv
// channel | signals                        | direction | transaction when
// input   | in_valid, rx_byte, step_count  | in        | in_valid  & !in_stall
// input   | in_stall                       | out       |
// output  | out_valid, digit_char, last_digit | out    | out_valid & !out_stall
// output  | out_stall                      | in        |
//
// a byte that is not a closing ':' of a GET frame is taken with no reply
// a reply runs shift-and-add-3 conversion over all COUNT_BITS bits, then skips leading zero
//   digits (none when saturated), then sends one digit per output transaction, held while out_stall
// one item is worked on at a time: in_stall is high until the last digit is taken
// rst is synchronous and clears the controller and the frame tracking
module get_command_decimal_reply
  import gcdr_pkg::*;
#(
  parameter int COUNT_BITS = 32,
  parameter int MAX_DIGITS = 10
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  rx_byte,
  input  logic [31:0] step_count,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [5:0]  digit_char,
  output logic        last_digit
);

  cmd_t    cmd;
  status_t status;

  // sequencing
  gcdr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd),
    .in_stall  (in_stall),
    .out_valid (out_valid)
  );

  // frame tracking and conversion
  gcdr_dpath #(
    .COUNT_BITS (COUNT_BITS),
    .MAX_DIGITS (MAX_DIGITS)
  ) u_dpath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .rx_byte    (rx_byte),
    .step_count (step_count),
    .status     (status),
    .digit_char (digit_char),
    .last_digit (last_digit)
  );

  // no input taken while a reply is out
  assert property (@(posedge clk) disable iff (rst) out_valid |-> in_stall)
    else $error("input ready during reply");

  // digits are always ascii decimal
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (digit_char >= CH_ZERO && digit_char <= CH_ZERO + 6'd9))
    else $error("digit out of range");

  // reply ends after the marked digit
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && last_digit) |=> !out_valid)
    else $error("output after last digit");

  // a reply only starts from a closing byte
  assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> (cmd.accept && rx_byte == CH_END))
    else $error("conversion started without a frame end");

endmodule
